// File: rtl/btkm_pkg.sv
//------------------------------------------------------------------------------
// btkm_pkg
// Shared types and constants for the binary trie key multiset.
//------------------------------------------------------------------------------
package btkm_pkg;

   localparam int NODE_POOL_DEF = 4096;
   localparam int KEY_BITS_DEF  = 32;
   localparam int KEY_W         = 32;
   localparam int KIND_W        = 2;
   localparam int STATUS_W      = 3;
   localparam int CNT_W         = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_SEARCH = 2'd2,
      KIND_OTHER  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_FOUND     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_IGNORED   = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      kind_type         kind;
      logic [KEY_W-1:0] key;
   } cmd_type;

endpackage

// File: rtl/btkm_if.sv
//------------------------------------------------------------------------------
// btkm_req_if / btkm_rsp_if
// Valid/ready channels for operation words and status words.
//------------------------------------------------------------------------------
interface btkm_req_if;
   logic                   valid;
   logic                   ready;
   btkm_pkg::kind_type     kind;
   logic [31:0]            key;
   modport source (output valid, kind, key, input ready);
   modport sink   (input valid, kind, key, output ready);
endinterface

interface btkm_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   modport source (output valid, status, input ready);
   modport sink   (input valid, status, output ready);
endinterface

// File: rtl/binary_trie_key_multiset_top.sv
// Check pass walks one trie level per cycle; update pass reads, then writes, each level.
// Throughput: one word at a time in the back end; a two-entry queue decouples the front.
// Reset: synchronous, active high; the root node is cleared before words are taken.
//------------------------------------------------------------------------------
// binary_trie_key_multiset_top
// Multiset of keys held in a binary trie of counted nodes.
//------------------------------------------------------------------------------
module binary_trie_key_multiset_top #(
   parameter int NODE_POOL = btkm_pkg::NODE_POOL_DEF,
   parameter int KEY_BITS  = btkm_pkg::KEY_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   btkm_req_if.sink  req,
   btkm_rsp_if.source rsp
);
   import btkm_pkg::*;

   cmd_type in_cmd, q_cmd;
   logic    q_valid, q_ready;

   assign in_cmd.kind = req.kind;
   assign in_cmd.key  = req.key;

   btkm_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_cmd (in_cmd),
      .q_valid, .q_ready, .q_cmd
   );

   btkm_back #(.NODE_POOL(NODE_POOL), .KEY_BITS(KEY_BITS)) u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_cmd,
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready), .rsp_status (rsp.status)
   );
endmodule

// File: rtl/btkm_front.sv
//------------------------------------------------------------------------------
// btkm_front
// Accepts operation words, folds unknown kinds into search, and queues them.
//------------------------------------------------------------------------------
module btkm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  btkm_pkg::cmd_type in_cmd,
   output logic              q_valid,
   input  logic              q_ready,
   output btkm_pkg::cmd_type q_cmd
);
   import btkm_pkg::*;

   cmd_type    slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic       push, pop;

   // classify: unknown kind behaves as search
   always_comb begin
      cls = in_cmd;
      if (in_cmd.kind == KIND_OTHER) cls.kind = KIND_SEARCH;
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_cmd    = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= cls;
   end
endmodule

// File: rtl/btkm_back.sv
//------------------------------------------------------------------------------
// btkm_back
// Walks the trie in node memory: a check pass, then an update pass if it changes.
//------------------------------------------------------------------------------
module btkm_back #(
   parameter int NODE_POOL = btkm_pkg::NODE_POOL_DEF,
   parameter int KEY_BITS  = btkm_pkg::KEY_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  btkm_pkg::cmd_type q_cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status
);
   import btkm_pkg::*;

   localparam int AW  = $clog2(NODE_POOL);
   localparam int FW  = AW + 1;
   localparam int LW  = $clog2(KEY_BITS + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CLEAR = 7'b0000010,
      S_CRD   = 7'b0000100,
      S_CCHK  = 7'b0001000,
      S_URD   = 7'b0010000,
      S_UWR   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   // node memories (one read port each, registered)
   logic [AW-1:0]    left_mem  [NODE_POOL];
   logic [AW-1:0]    right_mem [NODE_POOL];
   logic [1:0]       vbit_mem  [NODE_POOL];
   logic [CNT_W-1:0] cnt_mem   [NODE_POOL];

   state_type        st_ff, st_in;
   cmd_type          cmd_ff, cmd_in;
   logic [AW-1:0]    node_ff, node_in;
   logic [LW-1:0]    lvl_ff, lvl_in;       // levels still to walk
   logic [FW-1:0]    free_ff, free_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             rsat_ff, rsat_in;     // root count already at its maximum
   logic [2:0]       stat_ff, stat_in;
   logic             fresh_ff, fresh_in;   // node being visited was just allocated

   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    rd_left, rd_right;
   logic [1:0]       rd_vbit;
   logic [CNT_W-1:0] rd_cnt;

   logic             we_node;
   logic [AW-1:0]    wa_node;
   logic [AW-1:0]    wd_left, wd_right;
   logic             we_left, we_right;
   logic [1:0]       wd_vbit;
   logic [CNT_W-1:0] wd_cnt;

   logic             cur_bit, has_child, alloc_node, root_sat;
   logic [AW-1:0]    child;
   logic [FW-1:0]    avail;
   logic [63:0]      key_wide;

   // read node memories
   always_ff @(posedge clock) begin
      rd_left  <= left_mem[rd_addr];
      rd_right <= right_mem[rd_addr];
      rd_vbit  <= vbit_mem[rd_addr];
      rd_cnt   <= cnt_mem[rd_addr];
   end

   // write node memories
   always_ff @(posedge clock) begin
      if (we_node) begin
         vbit_mem[wa_node] <= wd_vbit;
         cnt_mem[wa_node]  <= wd_cnt;
      end
      if (we_left)  left_mem[wa_node]  <= wd_left;
      if (we_right) right_mem[wa_node] <= wd_right;
   end

   // key bit for the current level; bits above the key read as zero
   assign key_wide  = 64'(cmd_ff.key);
   assign cur_bit   = key_wide[6'(lvl_ff - 1'b1)];
   assign has_child = !fresh_ff && (cur_bit ? rd_vbit[1] : rd_vbit[0]);
   assign child     = cur_bit ? rd_right : rd_left;
   assign avail     = (free_ff < FW'(NODE_POOL)) ? FW'(NODE_POOL) - free_ff : '0;
   assign alloc_node = (lvl_ff != '0) && !has_child;
   assign root_sat  = (lvl_ff == LW'(KEY_BITS)) ? (rd_cnt == '1) : rsat_ff;

   assign q_ready    = (st_ff == S_IDLE);
   assign rsp_valid  = (st_ff == S_OUT);
   assign rsp_status = stat_ff;

   always_comb begin
      st_in    = st_ff;
      cmd_in   = cmd_ff;
      node_in  = node_ff;
      lvl_in   = lvl_ff;
      free_in  = free_ff;
      clr_in   = clr_ff;
      rsat_in  = rsat_ff;
      stat_in  = stat_ff;
      fresh_in = fresh_ff;
      rd_addr  = node_ff;
      we_node  = 1'b0;
      we_left  = 1'b0;
      we_right = 1'b0;
      wa_node  = node_ff;
      wd_vbit  = rd_vbit;
      wd_cnt   = rd_cnt;
      wd_left  = free_ff[AW-1:0];
      wd_right = free_ff[AW-1:0];
      case (st_ff)
         // zero the root's links and count after reset
         S_CLEAR: begin
            we_node = 1'b1;
            wa_node = clr_ff;
            wd_vbit = '0;
            wd_cnt  = '0;
            st_in   = S_IDLE;
         end
         S_IDLE: begin
            if (q_valid) begin
               cmd_in   = q_cmd;
               node_in  = '0;
               lvl_in   = LW'(KEY_BITS);
               fresh_in = 1'b0;
               rd_addr  = '0;
               st_in    = S_CCHK;
            end
         end
         S_CRD: begin
            st_in = S_CCHK;
         end
         // check pass: one level per cycle
         S_CCHK: begin
            if (cmd_ff.kind == KIND_INSERT) begin
               rsat_in = root_sat;
               if (lvl_ff == '0 || !has_child) begin
                  if (32'(lvl_ff) > 32'(avail) || root_sat) begin
                     stat_in = ST_FULL;
                     st_in   = S_OUT;
                  end else begin
                     node_in = '0;
                     lvl_in  = LW'(KEY_BITS);
                     rd_addr = '0;
                     st_in   = S_URD;
                  end
               end else begin
                  node_in = child;
                  lvl_in  = lvl_ff - 1'b1;
                  rd_addr = child;
                  st_in   = S_CCHK;
               end
            end else begin
               if (rd_cnt == '0) begin
                  stat_in = (cmd_ff.kind == KIND_DELETE) ? ST_IGNORED : ST_NOT_FOUND;
                  st_in   = S_OUT;
               end else if (lvl_ff == '0) begin
                  if (cmd_ff.kind == KIND_DELETE) begin
                     node_in = '0;
                     lvl_in  = LW'(KEY_BITS);
                     rd_addr = '0;
                     st_in   = S_URD;
                  end else begin
                     stat_in = ST_FOUND;
                     st_in   = S_OUT;
                  end
               end else if (!has_child) begin
                  stat_in = (cmd_ff.kind == KIND_DELETE) ? ST_IGNORED : ST_NOT_FOUND;
                  st_in   = S_OUT;
               end else begin
                  node_in = child;
                  lvl_in  = lvl_ff - 1'b1;
                  rd_addr = child;
               end
            end
         end
         S_URD: begin
            st_in = S_UWR;
         end
         // update pass: adjust count, link a new child where missing
         S_UWR: begin
            we_node = 1'b1;
            wd_vbit = fresh_ff ? 2'b00 : rd_vbit;
            if (cmd_ff.kind == KIND_INSERT) begin
               wd_cnt = (fresh_ff ? '0 : rd_cnt) + 1'b1;
               if (alloc_node) begin
                  wd_vbit[cur_bit] = 1'b1;
                  we_left  = !cur_bit;
                  we_right = cur_bit;
               end
            end else begin
               wd_cnt = rd_cnt - 1'b1;
            end
            if (lvl_ff == '0) begin
               stat_in = (cmd_ff.kind == KIND_INSERT) ? ST_INSERTED : ST_FOUND;
               st_in   = S_OUT;
            end else if (alloc_node) begin
               node_in  = free_ff[AW-1:0];
               free_in  = free_ff + 1'b1;
               fresh_in = 1'b1;
               lvl_in   = lvl_ff - 1'b1;
               rd_addr  = free_ff[AW-1:0];
               st_in    = S_URD;
            end else begin
               node_in  = child;
               fresh_in = 1'b0;
               lvl_in   = lvl_ff - 1'b1;
               rd_addr  = child;
               st_in    = S_URD;
            end
         end
         S_OUT: begin
            if (rsp_ready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_CLEAR;
         free_ff <= FW'(1);
         clr_ff  <= '0;
      end else begin
         st_ff   <= st_in;
         free_ff <= free_in;
         clr_ff  <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      node_ff  <= node_in;
      lvl_ff   <= lvl_in;
      rsat_ff  <= rsat_in;
      stat_ff  <= stat_in;
      fresh_ff <= fresh_in;
   end
endmodule

// File: rtl/btkm_checker.sv
//------------------------------------------------------------------------------
// btkm_checker
// Port-level checks on the trie block, bound to the top level.
//------------------------------------------------------------------------------
module btkm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status
);
   import btkm_pkg::*;

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FULL) else $error("bad status");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("status dropped");
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid) else $error("request dropped");
   a_no_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("response after reset");
endmodule

bind binary_trie_key_multiset_top btkm_checker u_chk (
   .clock, .reset,
   .req_valid (req.valid), .req_ready (req.ready),
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready), .rsp_status (rsp.status)
);

// File: tb/sv/btkm_tb_if.sv
//------------------------------------------------------------------------------
// btkm_tb_if
// The valid/ready channel interfaces come from the RTL file btkm_if.sv.
// This file adds no interface, only the package holding the watchdog limit,
// and is kept so that the file order stays package, interfaces, bench.
//------------------------------------------------------------------------------
package btkm_tb_pkg;
   localparam int WATCHDOG_LIMIT = 5000;
endpackage

// File: tb/sv/testbench.sv
//------------------------------------------------------------------------------
// testbench
// Drives insert, delete and search words into the trie multiset and checks
// every status word against a trie predictor kept inside the bench, or against
// the status typed in a row of the directed table. The table covers key extremes
// and every operation. Random traffic follows, mostly on keys already stored or
// in a narrow range, which may fill the node pool. Both channels idle at random.
//------------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import btkm_pkg::*;

   localparam int NODES = NODE_POOL_DEF;
   localparam int RANDOM_WORDS = 1500;

   typedef struct {
      kind_type         kind;
      logic [KEY_W-1:0] key;
      bit               typed;
      status_type       status;
   } row_type;

   logic clock;
   logic reset;
   btkm_req_if req_if ();
   btkm_rsp_if rsp_if ();

   binary_trie_key_multiset_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // Trie copy used for prediction
   logic [11:0]      left_child [NODES];
   logic [11:0]      right_child[NODES];
   logic [1:0]       child_ok   [NODES];
   logic [CNT_W-1:0] path_count [NODES];
   int unsigned      free_node;

   status_type       status_due[$];
   logic [KEY_W-1:0] stored_keys[$];
   bit               send_idle;
   bit               take_idle;
   int               errors;
   int               idle_cycles;
   int               n_status[5];
   int               n_words;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit child_of(int unsigned node, bit b, output int unsigned c);
      if (!child_ok[node][b]) return 1'b0;
      c = b ? right_child[node] : left_child[node];
      return c < NODES;
   endfunction

   function automatic bit key_stored(logic [KEY_W-1:0] key);
      int unsigned node;
      int unsigned c;
      node = 0;
      if (path_count[0] == 0) return 1'b0;
      for (int i = KEY_W - 1; i >= 0; i--) begin
         if (!child_of(node, key[i], c)) return 1'b0;
         node = c;
         if (path_count[node] == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic status_type trie_insert(logic [KEY_W-1:0] key);
      int unsigned node;
      int unsigned c;
      int unsigned missing;
      missing = 0;
      node = 0;
      for (int i = KEY_W - 1; i >= 0; i--) begin
         if (!child_of(node, key[i], c)) begin
            missing = i + 1;
            break;
         end
         node = c;
      end
      if (missing > NODES - free_node || path_count[0] == '1) return ST_FULL;
      node = 0;
      path_count[0]++;
      for (int i = KEY_W - 1; i >= 0; i--) begin
         if (!child_of(node, key[i], c)) begin
            c = free_node++;
            child_ok[c]   = 2'b00;
            path_count[c] = '0;
            if (key[i]) right_child[node] = c[11:0];
            else left_child[node] = c[11:0];
            child_ok[node][key[i]] = 1'b1;
         end
         node = c;
         path_count[node]++;
      end
      return ST_INSERTED;
   endfunction

   function automatic status_type trie_delete(logic [KEY_W-1:0] key);
      int unsigned node;
      int unsigned c;
      if (!key_stored(key)) return ST_IGNORED;
      node = 0;
      path_count[0]--;
      for (int i = KEY_W - 1; i >= 0; i--) begin
         if (!child_of(node, key[i], c)) break;
         node = c;
         if (path_count[node] != 0) path_count[node]--;
      end
      return ST_FOUND;
   endfunction

   function automatic status_type trie_apply(kind_type kind, logic [KEY_W-1:0] key);
      case (kind)
         KIND_INSERT: return trie_insert(key);
         KIND_DELETE: return trie_delete(key);
         default:     return key_stored(key) ? ST_FOUND : ST_NOT_FOUND;
      endcase
   endfunction

   // Offer one word, hold it until taken, then queue its status
   task automatic send_word(kind_type kind, logic [KEY_W-1:0] key, bit typed,
                            status_type typed_status);
      status_type st;
      @(negedge clock);
      while (send_idle && $urandom_range(99) < 34) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind  <= kind;
      req_if.key   <= key;
      do @(posedge clock); while (!req_if.ready);
      st = trie_apply(kind, key);
      if (kind == KIND_INSERT && st == ST_INSERTED) stored_keys.push_back(key);
      status_due.push_back(typed ? typed_status : st);
      n_words++;
   endtask

   // Random receiver stalls
   always @(negedge clock) begin
      rsp_if.ready <= !take_idle || $urandom_range(99) >= 34;
   end

   // Compare each status word with the oldest one due
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (status_due.size() == 0) begin
            $display("%0t: unexpected status word, actual %0d", $time, rsp_if.status);
            errors++;
         end else begin
            if (rsp_if.status !== status_due[0]) begin
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, status_due[0], rsp_if.status);
               errors++;
            end
            if (rsp_if.status < 5) n_status[rsp_if.status]++;
            void'(status_due.pop_front());
         end
      end
   end

   // Watchdog: count cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= btkm_tb_pkg::WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d status words due", $time, status_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      row_type          rows[$];
      logic [KEY_W-1:0] key;
      kind_type         kind;
      int               pick;

      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.kind  = KIND_SEARCH;
      req_if.key   = '0;
      send_idle    = 1'b1;
      take_idle    = 1'b1;
      errors       = 0;
      idle_cycles  = 0;
      n_words      = 0;
      free_node    = 1;
      foreach (child_ok[i]) begin
         child_ok[i]   = 2'b00;
         path_count[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: extremes, every kind, present and absent keys
      rows = '{
         '{KIND_SEARCH, 32'h0000_0000, 1, ST_NOT_FOUND},
         '{KIND_DELETE, 32'h0000_0000, 1, ST_IGNORED},
         '{KIND_OTHER,  32'hFFFF_FFFF, 1, ST_NOT_FOUND},
         '{KIND_INSERT, 32'h0000_0000, 1, ST_INSERTED},
         '{KIND_INSERT, 32'hFFFF_FFFF, 1, ST_INSERTED},
         '{KIND_SEARCH, 32'h0000_0000, 1, ST_FOUND},
         '{KIND_SEARCH, 32'hFFFF_FFFF, 1, ST_FOUND},
         '{KIND_SEARCH, 32'h0000_0001, 1, ST_NOT_FOUND},
         '{KIND_SEARCH, 32'h8000_0000, 1, ST_NOT_FOUND},
         '{KIND_OTHER,  32'h0000_0000, 1, ST_FOUND},
         '{KIND_INSERT, 32'h0000_0000, 1, ST_INSERTED},
         '{KIND_DELETE, 32'h0000_0000, 1, ST_FOUND},
         '{KIND_SEARCH, 32'h0000_0000, 1, ST_FOUND},
         '{KIND_DELETE, 32'h0000_0000, 1, ST_FOUND},
         '{KIND_SEARCH, 32'h0000_0000, 1, ST_NOT_FOUND},
         '{KIND_DELETE, 32'h0000_0000, 1, ST_IGNORED},
         '{KIND_DELETE, 32'hFFFF_FFFF, 1, ST_FOUND},
         '{KIND_SEARCH, 32'hFFFF_FFFF, 1, ST_NOT_FOUND},
         '{KIND_INSERT, 32'h8000_0000, 0, ST_INSERTED},
         '{KIND_INSERT, 32'h7FFF_FFFF, 0, ST_INSERTED},
         '{KIND_INSERT, 32'hAAAA_AAAA, 0, ST_INSERTED},
         '{KIND_INSERT, 32'h5555_5555, 0, ST_INSERTED},
         '{KIND_DELETE, 32'h5555_5554, 0, ST_IGNORED},
         '{KIND_OTHER,  32'h5555_5555, 0, ST_FOUND},
         '{KIND_SEARCH, 32'h7FFF_FFFE, 0, ST_FOUND}
      };
      foreach (rows[i]) send_word(rows[i].kind, rows[i].key, rows[i].typed, rows[i].status);

      // Random traffic: mostly stored keys or keys in a narrow range, some fully random ones
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         send_idle = !(n >= 300 && n < 600);
         take_idle = send_idle;
         if (n == 800) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            wait (status_due.size() == 0);
         end
         pick = $urandom_range(99);
         if (pick < 55) kind = KIND_INSERT;
         else if (pick < 80) kind = KIND_DELETE;
         else if (pick < 95) kind = KIND_SEARCH;
         else kind = KIND_OTHER;
         pick = $urandom_range(99);
         if (pick < 50 && stored_keys.size() > 0) begin
            key = stored_keys[$urandom_range(stored_keys.size() - 1)];
         end else if (pick < 80) begin
            key = {24'hC3A5_00 | 24'($urandom_range(3)), 8'($urandom)};
         end else begin
            key = $urandom;
         end
         send_word(kind, key, 1'b0, ST_INSERTED);
      end
      @(negedge clock);
      req_if.valid <= 1'b0;

      // Drain, then let the back end settle
      wait (status_due.size() == 0);
      repeat (150) @(posedge clock);
      $display("Sent %0d words: %0d inserted, %0d found, %0d not found,", n_words,
               n_status[ST_INSERTED], n_status[ST_FOUND], n_status[ST_NOT_FOUND]);
      $display("  %0d deletes ignored, %0d refused with pool full, %0d nodes used",
               n_status[ST_IGNORED], n_status[ST_FULL], free_node);
      if (errors == 0 && status_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
